/* src/acr_pkg.sv */
// ---------------------------------------------------------------------------
// acr_pkg
// Widths, limits and constants shared by the AC RMS accumulator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

  // window limit and accumulator widths
  localparam int MAX_SAMPLES = 65536;
  localparam int SMP_W       = 16;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = SMP_W + CNT_W;
  localparam int SQ_W        = 30 + CNT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  // result field widths
  localparam int FS_W      = 23;
  localparam int UV_W      = 23;
  localparam int RMS_W     = 24;
  localparam int OUT_CNT_W = 17;

  // serial multiplier: MUL_W x MUL_W
  localparam int MUL_W = 24;
  localparam int PRD_W = 2 * MUL_W;

  // variance and square root
  localparam int VAR_W = PRD_W;
  localparam int RT_W  = VAR_W / 2;

  // quotient bits kept from sumsq / n (mean square of a 16-bit sample)
  localparam int P1Q_W = 31;

  // mean numerator: |sum| * 256 plus rounding term
  localparam int MNUM_W = SUM_W + 8;

  // serial divider widths
  localparam int DVD_A = (SQ_W > MNUM_W) ? SQ_W : MNUM_W;
  localparam int DVD_W = (DVD_A > PRD_W) ? DVD_A : PRD_W;
  localparam int DVS_W = (CNT_W > 24) ? CNT_W : 24;

  // microvolt scaling: full_scale_uv * rms_q8 / (32767 * 256)
  localparam logic [DVS_W-1:0] UV_DIV   = DVS_W'(32767 * 256);
  localparam logic [UV_W-1:0]  UV_MAX   = '1;
  localparam logic [FS_W-1:0]  FS_RESET = FS_W'(2048000);

endpackage

`default_nettype wire

/* src/acr_mul.sv */
// ---------------------------------------------------------------------------
// acr_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module acr_mul
  import acr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             go_i,
  input  wire logic [MUL_W-1:0] a_i,
  input  wire logic [MUL_W-1:0] b_i,
  output logic                  done_o,
  output logic [PRD_W-1:0]      prod_o
);

  localparam int CW = $clog2(MUL_W + 1);

  logic [MUL_W-1:0] a_q, hi_q, lo_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q;
  logic [MUL_W:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        a_q   <= a_i;
        hi_q  <= '0;
        lo_q  <= b_i;
        cnt_q <= CW'(MUL_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        hi_q  <= sum[MUL_W:1];
        lo_q  <= {sum[0], lo_q[MUL_W-1:1]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

/* src/acr_div.sv */
// ---------------------------------------------------------------------------
// acr_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module acr_div
  import acr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             go_i,
  input  wire logic [DVD_W-1:0] dvd_i,
  input  wire logic [DVS_W-1:0] dvs_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quo_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q;
  logic [DVS_W:0]   rem_sh, diff;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = !diff[DVS_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        quo_q <= dvd_i;
        rem_q <= '0;
        dvs_q <= dvs_i;
        cnt_q <= CW'(DVD_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* src/acr_sqrt.sv */
// ---------------------------------------------------------------------------
// acr_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module acr_sqrt
  import acr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             go_i,
  input  wire logic [VAR_W-1:0] val_i,
  output logic                  done_o,
  output logic [RT_W-1:0]       root_o
);

  localparam int CW = $clog2(RT_W + 1);

  logic [VAR_W-1:0] val_q;
  logic [RT_W-1:0]  root_q;
  logic [RT_W+1:0]  rem_q, rem_sh, trial;
  logic [RT_W+2:0]  diff;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q, ge;

  assign rem_sh = {rem_q[RT_W-1:0], val_q[VAR_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign ge     = !diff[RT_W+2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        val_q  <= val_i;
        root_q <= '0;
        rem_q  <= '0;
        cnt_q  <= CW'(RT_W);
        run_q  <= 1'b1;
      end else if (run_q) begin
        val_q  <= {val_q[VAR_W-3:0], 2'b00};
        rem_q  <= ge ? diff[RT_W+1:0] : rem_sh;
        root_q <= {root_q[RT_W-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* src/ac_rms_accumulator.sv */
// ---------------------------------------------------------------------------
// ac_rms_accumulator
// Windowed AC RMS of signed converter samples from sum and sum of squares,
// built on a bit-serial multiplier, divider and square root.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------
//   sample   | start_i / busy_o          | sample_i, last_i
//   result   | valid_o (1-cycle strobe)  | rms_uv_o, rms_counts_q8_o,
//            |                           | sample_count_o, overflow_o
//   config   | full_scale_uv_we_i        | full_scale_uv_i
//
// a sample not marked last keeps busy_o high until the serial square is
// done; a dropped sample not marked last leaves busy_o low
// a last sample adds three serial divisions, two serial multiplies and
// a serial root before the result strobe, also if it is dropped
// the next sample can be taken in the cycle the result is shown
// reset clears the window and loads the default full scale; no clear pass
// the receiver cannot stall; results are shown once
// ---------------------------------------------------------------------------
`default_nettype none

module ac_rms_accumulator
  import acr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [SMP_W-1:0]     sample_i,
  input  wire logic                 last_i,
  input  wire logic                 full_scale_uv_we_i,
  input  wire logic [FS_W-1:0]      full_scale_uv_i,
  output logic                      valid_o,
  output logic [UV_W-1:0]           rms_uv_o,
  output logic [RMS_W-1:0]          rms_counts_q8_o,
  output logic [OUT_CNT_W-1:0]      sample_count_o,
  output logic                      overflow_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR,
    S_START,
    S_P1,
    S_MEAN,
    S_MSQ,
    S_ROOT,
    S_SCALE,
    S_UV
  } state_e;

  state_e state_q;

  logic [SMP_W-1:0]  sample_q;
  logic              last_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sq_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              drop_q;
  logic [FS_W-1:0]   fs_q;
  logic [VAR_W-1:0]  part1_q;
  logic [RMS_W-1:0]  rms_q;

  logic              mul_go_q, div_go_q, sqrt_go_q;
  logic [MUL_W-1:0]  mul_a_q, mul_b_q;
  logic [DVD_W-1:0]  div_n_q;
  logic [DVS_W-1:0]  div_d_q;
  logic [VAR_W-1:0]  sqrt_v_q;

  logic              valid_q;
  logic [UV_W-1:0]   uv_q;
  logic [RMS_W-1:0]  cnts_q;
  logic [OUT_CNT_W-1:0] scnt_q;
  logic              ovf_q;

  logic              mul_done, div_done, sqrt_done;
  logic [PRD_W-1:0]  mul_prod;
  logic [DVD_W-1:0]  div_quo;
  logic [RT_W-1:0]   sqrt_root;

  logic              accept;
  logic [SMP_W-1:0]  smp_mag;
  logic [SUM_W-1:0]  sum_mag;
  logic [MNUM_W-1:0] mean_num;
  logic [VAR_W-1:0]  var_val;

  acr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  acr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go_q),
    .dvd_i  (div_n_q),
    .dvs_i  (div_d_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  acr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (sqrt_go_q),
    .val_i  (sqrt_v_q),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign smp_mag = sample_i[SMP_W-1] ? (~sample_i + 1'b1) : sample_i;
  assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

  // floor of a negative mean: round the magnitude up
  assign mean_num = {sum_mag, 8'b0}
                  + (sum_q[SUM_W-1] ? MNUM_W'(cnt_q - 1'b1) : '0);

  assign var_val = (part1_q >= mul_prod) ? (part1_q - mul_prod) : (mul_prod - part1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sample_q  <= '0;
      last_q    <= 1'b0;
      sum_q     <= '0;
      sq_q      <= '0;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      fs_q      <= FS_RESET;
      part1_q   <= '0;
      rms_q     <= '0;
      mul_go_q  <= 1'b0;
      div_go_q  <= 1'b0;
      sqrt_go_q <= 1'b0;
      mul_a_q   <= '0;
      mul_b_q   <= '0;
      div_n_q   <= '0;
      div_d_q   <= '0;
      sqrt_v_q  <= '0;
      valid_q   <= 1'b0;
      uv_q      <= '0;
      cnts_q    <= '0;
      scnt_q    <= '0;
      ovf_q     <= 1'b0;
    end else begin
      mul_go_q  <= 1'b0;
      div_go_q  <= 1'b0;
      sqrt_go_q <= 1'b0;
      valid_q   <= 1'b0;

      if (full_scale_uv_we_i) begin
        fs_q <= full_scale_uv_i;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            sample_q <= sample_i;
            last_q   <= last_i;
            if (cnt_q < CNT_MAX) begin
              mul_go_q <= 1'b1;
              mul_a_q  <= MUL_W'(smp_mag);
              mul_b_q  <= MUL_W'(smp_mag);
              state_q  <= S_SQR;
            end else begin
              drop_q <= 1'b1;
              if (last_i) begin
                state_q <= S_START;
              end
            end
          end
        end
        S_SQR: begin
          if (mul_done) begin
            sum_q   <= sum_q + SUM_W'(signed'(sample_q));
            sq_q    <= sq_q + SQ_W'(mul_prod);
            cnt_q   <= cnt_q + 1'b1;
            state_q <= last_q ? S_START : S_IDLE;
          end
        end
        S_START: begin
          div_go_q <= 1'b1;
          div_n_q  <= DVD_W'(sq_q);
          div_d_q  <= DVS_W'(cnt_q);
          state_q  <= S_P1;
        end
        S_P1: begin
          if (div_done) begin
            part1_q  <= VAR_W'({div_quo[P1Q_W-1:0], 16'b0});
            div_go_q <= 1'b1;
            div_n_q  <= DVD_W'(mean_num);
            div_d_q  <= DVS_W'(cnt_q);
            state_q  <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mul_go_q <= 1'b1;
            mul_a_q  <= div_quo[MUL_W-1:0];
            mul_b_q  <= div_quo[MUL_W-1:0];
            state_q  <= S_MSQ;
          end
        end
        S_MSQ: begin
          if (mul_done) begin
            sqrt_go_q <= 1'b1;
            sqrt_v_q  <= var_val;
            state_q   <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            rms_q    <= RMS_W'(sqrt_root);
            mul_go_q <= 1'b1;
            mul_a_q  <= MUL_W'(fs_q);
            mul_b_q  <= MUL_W'(sqrt_root);
            state_q  <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (mul_done) begin
            div_go_q <= 1'b1;
            div_n_q  <= DVD_W'(mul_prod);
            div_d_q  <= UV_DIV;
            state_q  <= S_UV;
          end
        end
        S_UV: begin
          if (div_done) begin
            uv_q    <= (|div_quo[DVD_W-1:UV_W]) ? UV_MAX : div_quo[UV_W-1:0];
            cnts_q  <= rms_q;
            scnt_q  <= OUT_CNT_W'(cnt_q);
            ovf_q   <= drop_q;
            valid_q <= 1'b1;
            sum_q   <= '0;
            sq_q    <= '0;
            cnt_q   <= '0;
            drop_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign valid_o         = valid_q;
  assign rms_uv_o        = uv_q;
  assign rms_counts_q8_o = cnts_q;
  assign sample_count_o  = scnt_q;
  assign overflow_o      = ovf_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_window_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cnt_q == '0) && !drop_q && (sum_q == '0) && (sq_q == '0))
    else $error("window not cleared after result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("sample count beyond window limit");

  a_drop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cnt_q == CNT_MAX) && !last_i) |=> drop_q && !busy_o)
    else $error("sample on full window not flagged");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("busy while result shown");

endmodule

`default_nettype wire
